// ===== hw/rtl/sdp_pkg.sv =====
// sdp_pkg: types, codes and constants of the signed decimal parser
// used by the accumulate and range-check parts, the top level and its checker
package sdp_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int MAG_W       = VALUE_WIDTH - 1;
	localparam int PROD_W      = MAG_W + 4;
	localparam int DATA_W      = 64;
	localparam int CFG_IDX_W   = 2;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [3:0] RADIX    = 4'd10;

	localparam logic [MAG_W-1:0]  MAG_LIMIT = {MAG_W{1'b1}};
	localparam logic [DATA_W-1:0] MIN_RESET = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] MAX_RESET = {1'b0, {(DATA_W-1){1'b1}}};

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 2'd1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ERROR = 2'd1,
		ST_UNDER = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last;
		logic       empty_string;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		status_t           status;
	} result_t;

	// running state of the string being parsed
	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             negative;
		logic             at_first_char;
		logic             bad_string;
	} parse_state_t;

	// finished string, handed from the accumulator to the range check
	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             negative;
		logic             error;
	} fin_t;

	localparam parse_state_t STATE_RESET = '{
		magnitude:     '0,
		negative:      1'b0,
		at_first_char: 1'b1,
		bad_string:    1'b0
	};

endpackage

// ===== hw/rtl/sdp_accum.sv =====
// sdp_accum: one character step of the parser (sign, digit accumulate, exact overflow)
// depends on sdp_pkg
module sdp_accum (
	input  sdp_pkg::parse_state_t state,
	input  sdp_pkg::item_t        item,
	output sdp_pkg::parse_state_t state_nxt,
	output logic                  finish,
	output sdp_pkg::fin_t         fin
);
	import sdp_pkg::*;

	logic              is_sign;
	logic              num_char;
	logic [3:0]        digit;
	logic [PROD_W-1:0] prod;
	logic              too_big;
	parse_state_t      upd;

	assign is_sign  = state.at_first_char && ((item.char_byte == CH_MINUS) ||
	                                          (item.char_byte == CH_PLUS));
	assign num_char = (item.char_byte >= CH_ZERO) && (item.char_byte <= CH_NINE);
	assign digit    = 4'(item.char_byte - CH_ZERO);

	// magnitude * 10 + digit, exact against the largest magnitude
	assign prod    = PROD_W'(state.magnitude) * PROD_W'(RADIX) + PROD_W'(digit);
	assign too_big = prod > PROD_W'(MAG_LIMIT);

	always_comb begin
		upd               = state;
		upd.at_first_char = 1'b0;
		if (is_sign) begin
			upd.negative = (item.char_byte == CH_MINUS);
		end else if (num_char) begin
			if (!state.bad_string) begin
				if (too_big) begin
					upd.bad_string = 1'b1;
				end else begin
					upd.magnitude = MAG_W'(prod);
				end
			end
		end else begin
			upd.bad_string = 1'b1;
		end
	end

	always_comb begin
		finish    = item.empty_string || item.last;
		state_nxt = finish ? STATE_RESET : upd;
		fin.magnitude = upd.magnitude;
		fin.negative  = upd.negative;
		fin.error     = item.empty_string || upd.bad_string || is_sign;
	end

endmodule

// ===== hw/rtl/sdp_range.sv =====
// sdp_range: signs a finished magnitude and checks it against the min and max registers
// depends on sdp_pkg
module sdp_range (
	input  sdp_pkg::fin_t                fin,
	input  logic [sdp_pkg::DATA_W-1:0]   min_value,
	input  logic [sdp_pkg::DATA_W-1:0]   max_value,
	output sdp_pkg::result_t             res
);
	import sdp_pkg::*;

	logic [VALUE_WIDTH-1:0] mag_w;
	logic [VALUE_WIDTH-1:0] val_w;
	logic [DATA_W-1:0]      val;

	assign mag_w = VALUE_WIDTH'(fin.magnitude);
	assign val_w = fin.negative ? (~mag_w + VALUE_WIDTH'(1)) : mag_w;
	assign val   = DATA_W'($signed(val_w));

	always_comb begin
		if (fin.error) begin
			res.value  = '0;
			res.status = ST_ERROR;
		end else begin
			res.value = val;
			// underflow is tested first
			if ($signed(val) < $signed(min_value)) begin
				res.status = ST_UNDER;
			end else if ($signed(max_value) < $signed(val)) begin
				res.status = ST_OVER;
			end else begin
				res.status = ST_OK;
			end
		end
	end

endmodule

// ===== hw/rtl/signed_decimal_parser_range_check_top.sv =====
// signed_decimal_parser_range_check_top: decimal string to signed integer with range check
// depends on sdp_pkg, sdp_accum, sdp_range
//
//   channel   direction  handshake              payload
//   item      in         item_valid/item_stall  item_t: char_byte, last, empty_string
//   result    out        result_valid/stall     result_t: value, status
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data (min, max)
//
// one character per cycle while item_stall is low; the accumulate step is one constant multiply-add
// pipeline: input register (_s1), finished-string register (_s2), result register
// item_stall rises only when a finishing character waits behind a full _s2 and a
// stalled result; other characters keep flowing while a result waits
// reset clears the parse state, the valid bits and sets min/max to the full range
module signed_decimal_parser_range_check_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  sdp_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output sdp_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sdp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sdp_pkg::DATA_W-1:0]        cfg_data
);
	import sdp_pkg::*;

	// config registers
	logic [DATA_W-1:0] min_value_q;
	logic [DATA_W-1:0] max_value_q;

	// input stage
	logic  item_valid_s1;
	item_t item_s1;

	// parse state, updated once per character leaving _s1
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         s1_finish;
	fin_t         s1_fin;

	// finished string stage
	logic fin_valid_s2;
	fin_t fin_s2;

	// result register
	logic    res_valid_q;
	result_t res_q;
	result_t res_nxt;

	logic out_free;
	logic s2_free;
	logic s1_adv;

	// backpressure chain from the result side toward the input
	assign out_free   = !res_valid_q || !result_stall;
	assign s2_free    = !fin_valid_s2 || out_free;
	assign s1_adv     = item_valid_s1 && (!s1_finish || s2_free);
	assign item_stall = item_valid_s1 && !s1_adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_value_q <= MIN_RESET;
			max_value_q <= MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_VALUE: min_value_q <= cfg_data;
				CFG_MAX_VALUE: max_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: load whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	sdp_accum u_accum (
		.state     (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.finish    (s1_finish),
		.fin       (s1_fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	// finished string waits here for the range check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			fin_valid_s2 <= s1_adv && s1_finish;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_finish) begin
			fin_s2 <= s1_fin;
		end
	end

	sdp_range u_range (
		.fin       (fin_s2),
		.min_value (min_value_q),
		.max_value (max_value_q),
		.res       (res_nxt)
	);

	// result register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fin_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid_s2 && out_free) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hw/rtl/sdp_checker.sv =====
// sdp_checker: port-level assertions for the parser top level, bound to it
// depends on sdp_pkg and signed_decimal_parser_range_check_top
module sdp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input sdp_pkg::item_t                item,
	input logic                          result_valid,
	input logic                          result_stall,
	input sdp_pkg::result_t              result
);
	import sdp_pkg::*;

	// a stalled request stays offered and holds its payload
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("request dropped or changed under stall");

	// a stalled result stays and holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result dropped or changed under stall");

	// an error result always carries zero
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_ERROR) |-> (result.value == '0))
		else $error("error result with nonzero value");

	// a parsed magnitude never reaches the most negative pattern
	a_no_min_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_ERROR) |-> (result.value != MIN_RESET))
		else $error("parsed value out of magnitude range");

	// input is held back only while a result waits on a stalled receiver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a blocked result");

endmodule

bind signed_decimal_parser_range_check_top sdp_checker u_sdp_checker (.*);
